// ===== sv/free_list_slot_allocator_defines.svh =====
// Assertion macros shared by the allocator RTL.
`ifndef FREE_LIST_SLOT_ALLOCATOR_DEFINES_SVH
`define FREE_LIST_SLOT_ALLOCATOR_DEFINES_SVH

// Checked on every rising clock edge while reset is released.
`define FSLA_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define FSLA_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/fsla_pkg.sv =====
package fsla_pkg;

	// Fixed widths of the request and response fields.
	localparam int CMD_W  = 2;
	localparam int SLOT_W = 9;
	localparam int WORD_W = 32;
	localparam int STAT_W = 2;

	localparam int DEFAULT_SLOT_COUNT = 256;
	localparam int DEFAULT_DATA_BITS  = 32;

	localparam logic [CMD_W-1:0] CMD_OCCUPY  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;
	localparam logic [STAT_W-1:0] STAT_FREE  = 2'd3;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

endpackage

// ===== sv/free_list_slot_allocator.sv =====
// Slot allocator with a free chain, slots numbered from 1.
// Request channel (in_valid/in_ready): command, slot_number, write_data.
//   Occupy takes the head of the free chain or appends a new slot, stores
//   write_data and returns the slot in assigned_slot. Release pushes a busy
//   slot onto the free chain. Read returns a busy slot's data word.
// Response channel (out_valid/out_ready): status, assigned_slot, read_data,
//   high_water. Every request produces exactly one response, in order.
// Timing: a request is accepted in the idle cycle, the slot memories are read
//   at that edge, and the execute cycle computes the result, writes the memories
//   back and loads the response register. The response is valid from the edge
//   that ends the execute cycle; a new request is taken only once the block is
//   back in idle, as the link and data memories have a registered read port.
// The response register lets a new request enter while an earlier response
//   waits. If the receiver stalls and the register is still full, the block
//   holds in its execute cycle and accepts nothing further until it drains.
// Reset empties the free chain and the slot count; memory contents are left
//   as they are and no clearing pass is needed.
`include "free_list_slot_allocator_defines.svh"

module free_list_slot_allocator #(
	parameter int SLOT_COUNT = fsla_pkg::DEFAULT_SLOT_COUNT,
	parameter int DATA_BITS  = fsla_pkg::DEFAULT_DATA_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [fsla_pkg::CMD_W-1:0]    command,
	input  logic [fsla_pkg::SLOT_W-1:0]   slot_number,
	input  logic [fsla_pkg::WORD_W-1:0]   write_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [fsla_pkg::STAT_W-1:0]   status,
	output logic [fsla_pkg::SLOT_W-1:0]   assigned_slot,
	output logic [fsla_pkg::WORD_W-1:0]   read_data,
	output logic [fsla_pkg::SLOT_W-1:0]   high_water
);

	localparam int AW     = $clog2(SLOT_COUNT);
	localparam int IDX_W  = $clog2(SLOT_COUNT + 1);
	localparam int CMP_W  = (IDX_W > fsla_pkg::SLOT_W) ? IDX_W : fsla_pkg::SLOT_W;
	localparam int META_W = IDX_W + 1;

	fsla_pkg::state_t state_q, state_d;

	logic [IDX_W-1:0] free_head_q, free_head_d;
	logic [IDX_W-1:0] slots_used_q, slots_used_d;

	logic [fsla_pkg::CMD_W-1:0]  req_cmd_q;
	logic [fsla_pkg::SLOT_W-1:0] req_idx_q;
	logic [DATA_BITS-1:0]        req_data_q;

	logic                         out_valid_q;
	logic [fsla_pkg::STAT_W-1:0]  status_q;
	logic [fsla_pkg::SLOT_W-1:0]  assigned_slot_q;
	logic [fsla_pkg::WORD_W-1:0]  read_data_q;
	logic [fsla_pkg::SLOT_W-1:0]  high_water_q;

	logic accept, out_free, fire;

	// Meta word per slot: busy flag on top, free-chain link below.
	logic              meta_we, data_we;
	logic [AW-1:0]     meta_raddr, data_raddr, waddr;
	logic [META_W-1:0] meta_wdata, meta_rdata;
	logic [DATA_BITS-1:0] data_rdata;

	logic [IDX_W-1:0]            slot;
	logic                        in_range, busy;
	logic [IDX_W-1:0]            link;
	logic [fsla_pkg::STAT_W-1:0] res_status;
	logic [fsla_pkg::WORD_W-1:0] res_rdata;
	logic                        mem_write;

	assign in_ready = (state_q == fsla_pkg::S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign fire     = (state_q == fsla_pkg::S_EXEC) && out_free;

	// Occupy needs the link of the free head; release and read need the slot's flag.
	assign meta_raddr = (command == fsla_pkg::CMD_OCCUPY) ?
		AW'(free_head_q - IDX_W'(1)) : AW'(slot_number - fsla_pkg::SLOT_W'(1));
	assign data_raddr = AW'(slot_number - fsla_pkg::SLOT_W'(1));

	fsla_ram #(
		.WIDTH(META_W),
		.DEPTH(SLOT_COUNT)
	) u_meta_ram (
		.clk  (clk),
		.we   (meta_we),
		.waddr(waddr),
		.wdata(meta_wdata),
		.re   (accept),
		.raddr(meta_raddr),
		.rdata(meta_rdata)
	);

	fsla_ram #(
		.WIDTH(DATA_BITS),
		.DEPTH(SLOT_COUNT)
	) u_data_ram (
		.clk  (clk),
		.we   (data_we),
		.waddr(waddr),
		.wdata(req_data_q),
		.re   (accept),
		.raddr(data_raddr),
		.rdata(data_rdata)
	);

	assign busy     = meta_rdata[META_W-1];
	assign link     = meta_rdata[IDX_W-1:0];
	assign in_range = (req_idx_q != '0) && (CMP_W'(req_idx_q) <= CMP_W'(slots_used_q));

	always_comb begin
		res_status   = fsla_pkg::STAT_OK;
		res_rdata    = '0;
		slot         = '0;
		free_head_d  = free_head_q;
		slots_used_d = slots_used_q;
		mem_write    = 1'b0;
		waddr        = AW'(req_idx_q - fsla_pkg::SLOT_W'(1));
		meta_wdata   = {1'b0, free_head_q};
		data_we      = 1'b0;
		case (req_cmd_q)
			fsla_pkg::CMD_OCCUPY: begin
				if (free_head_q != '0) begin
					slot        = free_head_q;
					free_head_d = link;
				end else if (slots_used_q < IDX_W'(SLOT_COUNT)) begin
					slots_used_d = slots_used_q + IDX_W'(1);
					slot         = slots_used_d;
				end else begin
					res_status = fsla_pkg::STAT_FULL;
				end
				if (slot != '0) begin
					mem_write  = 1'b1;
					data_we    = fire;
					waddr      = AW'(slot - IDX_W'(1));
					meta_wdata = {1'b1, IDX_W'(0)};
				end
			end
			fsla_pkg::CMD_RELEASE: begin
				if (!in_range) begin
					res_status = fsla_pkg::STAT_RANGE;
				end else if (!busy) begin
					res_status = fsla_pkg::STAT_FREE;
				end else begin
					mem_write   = 1'b1;
					free_head_d = IDX_W'(req_idx_q);
				end
			end
			fsla_pkg::CMD_READ: begin
				if (!in_range) begin
					res_status = fsla_pkg::STAT_RANGE;
				end else if (!busy) begin
					res_status = fsla_pkg::STAT_FREE;
				end else begin
					res_rdata = fsla_pkg::WORD_W'(data_rdata);
				end
			end
			default: begin
			end
		endcase
	end

	assign meta_we = fire && mem_write;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fsla_pkg::S_IDLE: begin
				if (accept) begin
					state_d = fsla_pkg::S_EXEC;
				end
			end
			fsla_pkg::S_EXEC: begin
				if (out_free) begin
					state_d = fsla_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = fsla_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= fsla_pkg::S_IDLE;
			free_head_q  <= '0;
			slots_used_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fire) begin
				free_head_q  <= free_head_d;
				slots_used_q <= slots_used_d;
				out_valid_q  <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_cmd_q  <= command;
			req_idx_q  <= slot_number;
			req_data_q <= DATA_BITS'(write_data);
		end
		if (fire) begin
			status_q        <= res_status;
			assigned_slot_q <= fsla_pkg::SLOT_W'(slot);
			read_data_q     <= res_rdata;
			high_water_q    <= fsla_pkg::SLOT_W'(slots_used_d);
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign assigned_slot = assigned_slot_q;
	assign read_data     = read_data_q;
	assign high_water    = high_water_q;

	`FSLA_ASSERT_ALWAYS(a_used_bound, slots_used_q <= IDX_W'(SLOT_COUNT), "slot count exceeds store")
	`FSLA_ASSERT(a_head_appended, free_head_q <= slots_used_q, "free head beyond appended slots")
	`FSLA_ASSERT(a_accept_exec, accept |=> (state_q == fsla_pkg::S_EXEC), "accepted request not executed")
	`FSLA_ASSERT(a_fire_resp, fire |=> out_valid_q, "executed request produced no response")
	`FSLA_ASSERT(a_write_exec, (meta_we || data_we) |-> fire, "memory written outside execute cycle")

endmodule

// ===== sv/fsla_ram.sv =====
module fsla_ram #(
	parameter int WIDTH = fsla_pkg::DEFAULT_DATA_BITS,
	parameter int DEPTH = fsla_pkg::DEFAULT_SLOT_COUNT
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== tb/slot_allocator_checker.sv =====
module slot_allocator_checker
	import fsla_pkg::*;
#(
	parameter int SLOT_COUNT = DEFAULT_SLOT_COUNT,
	parameter int DATA_BITS  = DEFAULT_DATA_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [CMD_W-1:0]  command,
	input  logic [SLOT_W-1:0] slot_number,
	input  logic [WORD_W-1:0] write_data,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [STAT_W-1:0] status,
	input  logic [SLOT_W-1:0] assigned_slot,
	input  logic [WORD_W-1:0] read_data,
	input  logic [SLOT_W-1:0] high_water,
	output int                mismatch_count,
	output int                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [SLOT_W-1:0] slot;
		logic [WORD_W-1:0] word;
		logic [SLOT_W-1:0] appended;
	} slot_response_t;

	localparam int KEPT_BITS = (DATA_BITS < WORD_W) ? DATA_BITS : WORD_W;
	localparam logic [WORD_W-1:0] WORD_MASK = {WORD_W{1'b1}} >> (WORD_W - KEPT_BITS);

	logic [WORD_W-1:0] stored_word [1:SLOT_COUNT];
	bit                slot_held [1:SLOT_COUNT];
	logic [SLOT_W-1:0] link_of [1:SLOT_COUNT];
	logic [SLOT_W-1:0] chain_head;
	int                appended_count;
	int                mismatch_total;
	int                response_no;
	slot_response_t    expected_q[$];

	assign mismatch_count = mismatch_total;

	initial begin
		mismatch_total = 0;
		response_no = 0;
	end

	// Updates the allocator state for one request and returns the response it should give.
	function automatic slot_response_t apply_request(input logic [CMD_W-1:0] cmd,
			input logic [SLOT_W-1:0] idx, input logic [WORD_W-1:0] word);
		slot_response_t rsp;
		int slot;
		bit in_range;
		rsp = '0;
		rsp.status = STAT_OK;
		slot = 0;
		in_range = (idx >= 1) && (idx <= appended_count);
		case (cmd)
			CMD_OCCUPY: begin
				if (chain_head != '0) begin
					slot = chain_head;
					chain_head = link_of[slot];
				end else if (appended_count < SLOT_COUNT) begin
					appended_count++;
					slot = appended_count;
				end else begin
					rsp.status = STAT_FULL;
				end
				if (slot != 0) begin
					slot_held[slot] = 1'b1;
					stored_word[slot] = word & WORD_MASK;
					rsp.slot = slot[SLOT_W-1:0];
				end
			end
			CMD_RELEASE: begin
				if (!in_range) begin
					rsp.status = STAT_RANGE;
				end else if (!slot_held[idx]) begin
					rsp.status = STAT_FREE;
				end else begin
					slot_held[idx] = 1'b0;
					link_of[idx] = chain_head;
					chain_head = idx;
				end
			end
			CMD_READ: begin
				if (!in_range) begin
					rsp.status = STAT_RANGE;
				end else if (!slot_held[idx]) begin
					rsp.status = STAT_FREE;
				end else begin
					rsp.word = stored_word[idx];
				end
			end
			default: begin
			end
		endcase
		rsp.appended = appended_count[SLOT_W-1:0];
		return rsp;
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_total++;
		$display("%0t ns: MISMATCH response %0d: %s", $time, response_no, what);
	endtask

	always @(posedge clk or negedge arst_n) begin
		slot_response_t want;
		if (!arst_n) begin
			chain_head = '0;
			appended_count = 0;
			expected_q.delete();
			pending <= 0;
		end else begin
			// A response accepted at this edge always belongs to an earlier request.
			if (out_valid && out_ready) begin
				response_no++;
				if (expected_q.size() == 0) begin
					report_mismatch($sformatf("no request outstanding (status %0d slot %0d)",
						status, assigned_slot));
				end else begin
					want = expected_q.pop_front();
					if (status !== want.status) begin
						report_mismatch($sformatf("status %0d, expected %0d",
							status, want.status));
					end
					if (assigned_slot !== want.slot) begin
						report_mismatch($sformatf("assigned_slot %0d, expected %0d",
							assigned_slot, want.slot));
					end
					if (read_data !== want.word) begin
						report_mismatch($sformatf("read_data %h, expected %h",
							read_data, want.word));
					end
					if (high_water !== want.appended) begin
						report_mismatch($sformatf("high_water %0d, expected %0d",
							high_water, want.appended));
					end
				end
			end
			if (in_valid && in_ready) begin
				expected_q.push_back(apply_request(command, slot_number, write_data));
			end
			pending <= expected_q.size();
		end
	end

endmodule

// ===== tb/tb_free_list_slot_allocator.sv =====
module tb_free_list_slot_allocator;
	timeunit 1ns;
	timeprecision 1ps;
	import fsla_pkg::*;

	localparam int SLOTS = DEFAULT_SLOT_COUNT;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef enum int {
		PH_FILL,
		PH_DRAIN,
		PH_MIX
	} phase_kind_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [CMD_W-1:0]  command;
	logic [SLOT_W-1:0] slot_number;
	logic [WORD_W-1:0] write_data;
	logic              out_valid;
	logic              out_ready;
	logic [STAT_W-1:0] status;
	logic [SLOT_W-1:0] assigned_slot;
	logic [WORD_W-1:0] read_data;
	logic [SLOT_W-1:0] high_water;

	int mismatches;
	int in_flight;
	int occupies_sent;
	int tx_steady_left;

	free_list_slot_allocator #(
		.SLOT_COUNT(SLOTS),
		.DATA_BITS (DEFAULT_DATA_BITS)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.slot_number  (slot_number),
		.write_data   (write_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.assigned_slot(assigned_slot),
		.read_data    (read_data),
		.high_water   (high_water)
	);

	slot_allocator_checker #(
		.SLOT_COUNT(SLOTS),
		.DATA_BITS (DEFAULT_DATA_BITS)
	) u_slot_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.slot_number   (slot_number),
		.write_data    (write_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.assigned_slot (assigned_slot),
		.read_data     (read_data),
		.high_water    (high_water),
		.mismatch_count(mismatches),
		.pending       (in_flight)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("free_list_slot_allocator verification failed");
		$finish;
	end

	// Mostly short idle stretches, now and then a long one.
	function automatic int idle_length();
		if ($urandom_range(9) < 8) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [WORD_W-1:0] random_word();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return $urandom();
		endcase
	endfunction

	// Aim most indexes at slots that may have been appended, so that releases and
	// reads mostly hit real slots; the rest probe zero, the top of the range or any index.
	function automatic int random_slot();
		int top_slot;
		top_slot = (occupies_sent < 1) ? 1 : occupies_sent;
		case ($urandom_range(19))
			0: return 0;
			1: return SLOTS;
			2: return $urandom_range(0, SLOTS);
			default: return $urandom_range(1, top_slot);
		endcase
	endfunction

	task automatic send_request(input logic [CMD_W-1:0] cmd, input int slot,
			input logic [WORD_W-1:0] word);
		int gap;
		if (tx_steady_left > 0) begin
			tx_steady_left--;
			gap = 0;
		end else if ($urandom_range(49) == 0) begin
			tx_steady_left = $urandom_range(20, 80);
			gap = 0;
		end else begin
			gap = ($urandom_range(1) == 0) ? 0 : idle_length();
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		slot_number <= slot[SLOT_W-1:0];
		write_data <= word;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (cmd == CMD_OCCUPY && occupies_sent < SLOTS) occupies_sent++;
	endtask

	task automatic wait_until_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (in_flight != 0) @(posedge clk);
	endtask

	task automatic random_phase(input phase_kind_t kind, input int count);
		int occupy_pct;
		int release_pct;
		int pick;
		logic [CMD_W-1:0] cmd;
		case (kind)
			PH_FILL: begin
				occupy_pct = 85;
				release_pct = 7;
			end
			PH_DRAIN: begin
				occupy_pct = 20;
				release_pct = 55;
			end
			default: begin
				occupy_pct = 45;
				release_pct = 30;
			end
		endcase
		repeat (count) begin
			pick = $urandom_range(99);
			if (pick < occupy_pct) cmd = CMD_OCCUPY;
			else if (pick < occupy_pct + release_pct) cmd = CMD_RELEASE;
			else if (pick < 97) cmd = CMD_READ;
			else cmd = CMD_UNUSED;
			send_request(cmd, random_slot(), random_word());
		end
	endtask

	// Response side: random stalls with occasional stretches of steady acceptance.
	initial begin
		int stall_left;
		int steady_left;
		stall_left = 0;
		steady_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (steady_left > 0) begin
				steady_left--;
				out_ready <= 1'b1;
			end else if ($urandom_range(59) == 0) begin
				steady_left = $urandom_range(20, 80);
				out_ready <= 1'b1;
			end else if ($urandom_range(3) != 0) begin
				out_ready <= 1'b1;
			end else begin
				stall_left = idle_length() - 1;
				out_ready <= 1'b0;
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		command <= CMD_OCCUPY;
		slot_number <= '0;
		write_data <= '0;
		occupies_sent = 0;
		tx_steady_left = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Append three slots, then read the first two back and probe the range checks.
		send_request(CMD_OCCUPY, 0, '0);
		send_request(CMD_OCCUPY, 0, '1);
		send_request(CMD_OCCUPY, SLOTS, 32'hA5A5_5A5A);
		send_request(CMD_READ, 1, '0);
		send_request(CMD_READ, 2, '0);
		send_request(CMD_READ, 0, '1);
		send_request(CMD_READ, 4, '0);
		send_request(CMD_READ, SLOTS, '0);
		// A double release and a read of a freed slot report the slot as free.
		send_request(CMD_RELEASE, 2, '0);
		send_request(CMD_RELEASE, 2, '0);
		send_request(CMD_READ, 2, '0);
		send_request(CMD_RELEASE, 0, '0);
		send_request(CMD_RELEASE, SLOTS, '1);
		send_request(CMD_UNUSED, SLOTS, '1);
		// The free chain hands slots back last released first, then appends again.
		send_request(CMD_RELEASE, 3, '0);
		send_request(CMD_RELEASE, 1, '0);
		send_request(CMD_OCCUPY, 0, 32'h0000_0001);
		send_request(CMD_OCCUPY, 0, 32'h8000_0000);
		send_request(CMD_OCCUPY, 0, 32'h1234_5678);
		send_request(CMD_OCCUPY, 0, 32'hFFFF_0000);
		send_request(CMD_READ, 3, '0);
		send_request(CMD_READ, 4, '0);

		// The first fill runs the store into the full condition.
		random_phase(PH_FILL, 400);
		wait_until_drained();
		random_phase(PH_DRAIN, 300);
		random_phase(PH_FILL, 300);
		wait_until_drained();
		repeat (3) random_phase(phase_kind_t'($urandom_range(2)), 200);

		wait_until_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("free_list_slot_allocator verification clean");
		end else begin
			$display("free_list_slot_allocator verification failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+sv
sv/fsla_pkg.sv
sv/fsla_ram.sv
sv/free_list_slot_allocator.sv
tb/slot_allocator_checker.sv
tb/tb_free_list_slot_allocator.sv
